// File: sv/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared constants, register map and types for the sky separation core.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int FRAC_BITS = 32;
  localparam int DATA_W    = 64;
  localparam int PER_W     = 63;
  localparam int RR_W      = 32;
  localparam int IP_W      = 36;
  localparam int ADDR_W    = 6;

  // 2*pi in Q60, truncated
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam int ANG_SHIFT = 60 - FRAC_BITS;
  localparam int ANG_NW    = 128 - ANG_SHIFT;

  // radicand is below 2^74, so the root fits in 37 bits
  localparam int SQ_BITS = 37;
  localparam int RAD_W   = 2 * SQ_BITS;

  localparam logic [63:0] FAR_VALUE = 64'd100 << FRAC_BITS;

  // register indexes (byte address / 8)
  localparam logic [2:0] REG_EPOCH  = 3'd0;
  localparam logic [2:0] REG_PERIOD = 3'd1;
  localparam logic [2:0] REG_RR     = 3'd2;
  localparam logic [2:0] REG_IP     = 3'd3;
  localparam logic [2:0] REG_DUR    = 3'd4;
  localparam logic [2:0] REG_MODE   = 3'd5;

  typedef struct packed {
    logic [DATA_W-1:0] epoch;
    logic [PER_W-1:0]  period;
    logic [RR_W-1:0]   radius_ratio;
    logic [IP_W-1:0]   impact_param;
    logic [PER_W-1:0]  duration;
    logic              angle_mode;
  } cfg_t;

endpackage

// File: sv/tss_cfg.sv
// ----------------------------------------------------------------------------
// tss_cfg
// APB register file holding the orbit settings.
// ----------------------------------------------------------------------------
module tss_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tss_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready,
  output tss_pkg::cfg_t             cfg_o
);

  tss_pkg::cfg_t cfg_q;
  logic [2:0]    idx;
  logic          wr;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr     = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.epoch        <= '0;
      cfg_q.period       <= tss_pkg::PER_W'(64'd1 << tss_pkg::FRAC_BITS);
      cfg_q.radius_ratio <= 32'd429496730;
      cfg_q.impact_param <= '0;
      cfg_q.duration     <= tss_pkg::PER_W'(64'd429496730);
      cfg_q.angle_mode   <= 1'b0;
    end else if (wr) begin
      case (idx)
        tss_pkg::REG_EPOCH:  cfg_q.epoch        <= pwdata;
        tss_pkg::REG_PERIOD: cfg_q.period       <= pwdata[62:0];
        tss_pkg::REG_RR:     cfg_q.radius_ratio <= pwdata[31:0];
        tss_pkg::REG_IP:     cfg_q.impact_param <= pwdata[35:0];
        tss_pkg::REG_DUR:    cfg_q.duration     <= pwdata[62:0];
        tss_pkg::REG_MODE:   cfg_q.angle_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tss_pkg::REG_EPOCH:  prdata = cfg_q.epoch;
      tss_pkg::REG_PERIOD: prdata = {1'b0, cfg_q.period};
      tss_pkg::REG_RR:     prdata = {32'd0, cfg_q.radius_ratio};
      tss_pkg::REG_IP:     prdata = {28'd0, cfg_q.impact_param};
      tss_pkg::REG_DUR:    prdata = {1'b0, cfg_q.duration};
      tss_pkg::REG_MODE:   prdata = {63'd0, cfg_q.angle_mode};
      default:             prdata = '0;
    endcase
  end

endmodule

// File: sv/tss_div_pipe.sv
// ----------------------------------------------------------------------------
// tss_div_pipe
// Restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module tss_div_pipe #(
  parameter int NW = 64,
  parameter int DW = 63,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] rem_i,
  input  logic [SW-1:0] side_i,
  input  logic [DW-1:0] d_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  // dividend bits shift out at the top while quotient bits shift in below
  logic [NW:0]   vld_s;
  logic [NW-1:0] num_s  [NW+1];
  logic [DW-1:0] rem_s  [NW+1];
  logic [SW-1:0] side_s [NW+1];

  assign vld_s[0]  = valid_i;
  assign num_s[0]  = num_i;
  assign rem_s[0]  = rem_i;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    assign trial = {rem_s[k], num_s[k][NW-1]};
    assign ge    = trial >= {1'b0, d_i};
    assign diff  = trial - {1'b0, d_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        num_s[k+1]  <= {num_s[k][NW-2:0], ge};
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign valid_o = vld_s[NW];
  assign quo_o   = num_s[NW];
  assign rem_o   = rem_s[NW];
  assign side_o  = side_s[NW];

endmodule

// File: sv/tss_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// tss_sqrt_pipe
// Digit-by-digit integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module tss_sqrt_pipe #(
  parameter int SQ = 37,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*SQ-1:0] rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [SQ-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  localparam int RW = 2 * SQ;

  logic [SQ:0]   vld_s;
  logic [RW-1:0] rad_s  [SQ+1];
  logic [SQ+1:0] rem_s  [SQ+1];
  logic [SQ-1:0] root_s [SQ+1];
  logic [SW-1:0] side_s [SQ+1];

  assign vld_s[0]  = valid_i;
  assign rad_s[0]  = rad_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < SQ; k++) begin : g_stage
    logic [SQ+3:0] cur;
    logic [SQ+3:0] trial;
    logic          ge;
    logic [SQ+3:0] diff;

    assign cur   = {rem_s[k], rad_s[k][RW-1 -: 2]};
    assign trial = {2'b00, root_s[k], 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1]  <= ge ? diff[SQ+1:0] : cur[SQ+1:0];
        root_s[k+1] <= {root_s[k][SQ-2:0], ge};
        rad_s[k+1]  <= {rad_s[k][RW-3:0], 2'b00};
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign valid_o = vld_s[SQ];
  assign root_o  = root_s[SQ];
  assign side_o  = side_s[SQ];

endmodule

// File: sv/transit_sky_separation_core.sv
// ----------------------------------------------------------------------------
// transit_sky_separation_core
// Per-sample orbital angle or sky separation of a transiting planet, Q32.32.
// ----------------------------------------------------------------------------
//  channel   | dir | beat contents
//  s_axis    | in  | tdata[63:0] sample_time (signed Q32.32)
//  m_axis    | out | tdata[63:0] value (signed Q32.32)
//  apb       | in  | six 64-bit registers at byte address 8*index
//
//  One beat is accepted per cycle while m_axis is not stalled; the pipe is
//  3 front stages, 100-bit divider, fold, 64-bit divider, 4 multiply and
//  radicand stages, 37-stage root, output register.
//  Reset clears only the valid bits and sets the registers to their defaults; no clearing pass.
//  A stall on m_axis freezes the whole pipe, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module transit_sky_separation_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [63:0]                s_axis_tdata,  // [63:0] sample_time
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [63:0]                m_axis_tdata,  // [63:0] value
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tss_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  localparam int SQ = tss_pkg::SQ_BITS;
  localparam int NA = tss_pkg::ANG_NW;

  tss_pkg::cfg_t cfg;

  tss_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  // zero period or duration acts as one LSB
  logic [62:0] per, dur;
  assign per = (cfg.period == '0) ? 63'd1 : cfg.period;
  assign dur = (cfg.duration == '0) ? 63'd1 : cfg.duration;

  logic en;
  logic out_vld_q;
  logic [63:0] out_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---- stage 1: signed difference as sign and magnitude
  logic [63:0] su, eu;
  logic        s1_vld_q, s1_neg_q, s1_mode_q;
  logic [63:0] s1_mag_q;
  assign su = s_axis_tdata ^ 64'h8000000000000000;
  assign eu = cfg.epoch ^ 64'h8000000000000000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_neg_q  <= su < eu;
      s1_mag_q  <= (su < eu) ? eu - su : su - eu;
      s1_mode_q <= cfg.angle_mode;
    end
  end

  // ---- stage 2: partial products of |t| * 2pi
  logic        s2_vld_q, s2_neg_q, s2_mode_q;
  logic [63:0] s2_mag_q, s2_p00_q, s2_p01_q, s2_p10_q, s2_p11_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_neg_q  <= s1_neg_q;
      s2_mode_q <= s1_mode_q;
      s2_mag_q  <= s1_mag_q;
      s2_p00_q  <= 64'(s1_mag_q[31:0])  * 64'(tss_pkg::TWO_PI_Q60[31:0]);
      s2_p01_q  <= 64'(s1_mag_q[31:0])  * 64'(tss_pkg::TWO_PI_Q60[63:32]);
      s2_p10_q  <= 64'(s1_mag_q[63:32]) * 64'(tss_pkg::TWO_PI_Q60[31:0]);
      s2_p11_q  <= 64'(s1_mag_q[63:32]) * 64'(tss_pkg::TWO_PI_Q60[63:32]);
    end
  end

  // ---- stage 3: sum, pick the dividend (scaled angle or |t| for the fold)
  logic [127:0] prod;
  logic         s3_vld_q, s3_neg_q, s3_mode_q;
  logic [NA-1:0] s3_num_q;
  assign prod = {64'd0, s2_p00_q} + ({64'd0, s2_p01_q} << 32)
              + ({64'd0, s2_p10_q} << 32) + {s2_p11_q, 64'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_neg_q  <= s2_neg_q;
      s3_mode_q <= s2_mode_q;
      s3_num_q  <= s2_mode_q ? prod[127:tss_pkg::ANG_SHIFT] : NA'(s2_mag_q);
    end
  end

  // ---- divider 1: angle quotient, or |t| mod period
  logic          d1_vld;
  logic [NA-1:0] d1_quo;
  logic [62:0]   d1_rem;
  logic [1:0]    d1_side;

  tss_div_pipe #(.NW(NA), .DW(63), .SW(2)) u_div_phase (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s3_vld_q), .num_i(s3_num_q),
    .rem_i(63'd0), .side_i({s3_mode_q, s3_neg_q}), .d_i(per),
    .valid_o(d1_vld), .quo_o(d1_quo), .rem_o(d1_rem), .side_o(d1_side)
  );

  // ---- stage 4: fold phase, far test, angle saturation
  logic [62:0] m_fold;
  logic [63:0] ang;
  logic        s4_vld_q, s4_alt_use_q;
  logic [62:0] s4_m_q;
  logic [63:0] s4_alt_q;
  assign m_fold = ({d1_rem, 1'b0} > {1'b0, per}) ? per - d1_rem : d1_rem;

  always_comb begin
    if (d1_side[0]) begin
      ang = (d1_quo > NA'(64'h8000000000000000)) ? 64'h8000000000000000
                                                 : 64'd0 - d1_quo[63:0];
    end else begin
      ang = (d1_quo[NA-1:63] != '0) ? 64'h7FFFFFFFFFFFFFFF : d1_quo[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= d1_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_m_q       <= m_fold;
      s4_alt_use_q <= d1_side[1] || (m_fold > dur);
      s4_alt_q     <= d1_side[1] ? ang : tss_pkg::FAR_VALUE;
    end
  end

  // ---- divider 2: g = m * 2^63 / T14 (m <= T14, so the top half starts at m/2)
  logic        d2_vld;
  logic [63:0] d2_g;
  logic [62:0] d2_rem;
  logic [64:0] d2_side;

  tss_div_pipe #(.NW(64), .DW(63), .SW(65)) u_div_scale (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s4_vld_q), .num_i({s4_m_q[0], 63'd0}),
    .rem_i({1'b0, s4_m_q[62:1]}), .side_i({s4_alt_use_q, s4_alt_q}), .d_i(dur),
    .valid_o(d2_vld), .quo_o(d2_g), .rem_o(d2_rem), .side_o(d2_side)
  );

  // ---- stage 5: partial products of (1+rp)*g and b*g
  logic [32:0] a_coef;
  logic        s5_vld_q;
  logic [64:0] s5_side_q;
  logic [64:0] s5_pa_lo_q, s5_pa_hi_q;
  logic [67:0] s5_pb_lo_q, s5_pb_hi_q;
  assign a_coef = (33'd1 << tss_pkg::FRAC_BITS) + 33'(cfg.radius_ratio);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= d2_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_side_q  <= d2_side;
      s5_pa_lo_q <= 65'(a_coef) * 65'(d2_g[31:0]);
      s5_pa_hi_q <= 65'(a_coef) * 65'(d2_g[63:32]);
      s5_pb_lo_q <= 68'(cfg.impact_param) * 68'(d2_g[31:0]);
      s5_pb_hi_q <= 68'(cfg.impact_param) * 68'(d2_g[63:32]);
    end
  end

  // ---- stage 6: P and Q (Q2F) from the Q63 scaling
  logic [96:0] ag;
  logic [99:0] bg;
  logic        s6_vld_q;
  logic [64:0] s6_side_q;
  logic [33:0] s6_p_q;
  logic [36:0] s6_qv_q;
  assign ag = 97'(s5_pa_lo_q) + {s5_pa_hi_q, 32'd0};
  assign bg = 100'(s5_pb_lo_q) + {s5_pb_hi_q, 32'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (en) begin
      s6_vld_q <= s5_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_side_q <= s5_side_q;
      s6_p_q    <= ag[96:63];
      s6_qv_q   <= bg[99:63];
    end
  end

  // ---- stage 7: squares
  logic        s7_vld_q;
  logic [64:0] s7_side_q;
  logic [67:0] s7_p2_q;
  logic [73:0] s7_q2_q;
  logic [71:0] s7_b2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (en) begin
      s7_vld_q <= s6_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_side_q <= s6_side_q;
      s7_p2_q   <= 68'(s6_p_q) * 68'(s6_p_q);
      s7_q2_q   <= 74'(s6_qv_q) * 74'(s6_qv_q);
      s7_b2_q   <= 72'(cfg.impact_param) * 72'(cfg.impact_param);
    end
  end

  // ---- stage 8: radicand b^2 + P^2 - Q^2, clamped at zero
  logic [73:0] rsum;
  logic        s8_vld_q;
  logic [64:0] s8_side_q;
  logic [73:0] s8_rad_q;
  assign rsum = 74'(s7_b2_q) + 74'(s7_p2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
    end else if (en) begin
      s8_vld_q <= s7_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_side_q <= s7_side_q;
      s8_rad_q  <= (s7_q2_q <= rsum) ? rsum - s7_q2_q : '0;
    end
  end

  // ---- root
  logic          sq_vld;
  logic [SQ-1:0] sq_root;
  logic [64:0]   sq_side;

  tss_sqrt_pipe #(.SQ(SQ), .SW(65)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s8_vld_q), .rad_i(s8_rad_q),
    .side_i(s8_side_q), .valid_o(sq_vld), .root_o(sq_root), .side_o(sq_side)
  );

  // ---- output register; holds its beat while m_axis stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= sq_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= sq_side[64] ? sq_side[63:0] : 64'(sq_root);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
